FILE: hw/rtl/rmt_pkg.sv
`default_nettype none

package rmt_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(2 * CAPACITY);
    localparam int NODE_W   = ADDR_W + 1;
    localparam int POS_W    = 11;
    localparam int WORD_W   = 32;
    localparam int DEPTH    = 2 * CAPACITY;

    localparam logic [POS_W-1:0]         USED_SIZE_RST = POS_W'(1024);
    localparam logic signed [WORD_W-1:0] EMPTY_MARK    = -WORD_W'(32'h3f3f3f3f);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [NODE_W-1:0]        t_node;
    typedef logic [POS_W-1:0]         t_pos;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_QA,
        ST_QB
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    function automatic t_word smax(t_word a, t_word b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rmt_ram.sv
`default_nettype none

module rmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/rmt_ctrl.sv
`default_nettype none

module rmt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_operation,
    input  wire rmt_pkg::t_pos     i_left,
    input  wire rmt_pkg::t_pos     i_right,
    input  wire rmt_pkg::t_word    i_value,
    input  wire rmt_pkg::t_pos     i_size,
    output rmt_pkg::t_mem_req      o_mem_req,
    input  wire rmt_pkg::t_word    i_mem_rdata,
    output logic                   o_valid,
    output rmt_pkg::t_word         o_maximum
);

    import rmt_pkg::*;

    t_state r_state, n_state;
    t_addr  r_node, n_node;
    logic   r_first, n_first;
    t_word  r_cur, n_cur;
    t_node  r_a, n_a;
    t_node  r_b, n_b;
    t_word  r_best, n_best;
    logic   r_pend, n_pend;
    logic   r_out_valid, n_out_valid;
    t_word  r_max, n_max;

    t_mem_req mem_req;
    t_word    walk_val;
    t_word    fold;
    t_pos     q_lo;
    t_pos     q_hi;
    t_node    b_dec;
    logic     accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_node      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_first     <= n_first;
        end
        r_cur  <= n_cur;
        r_a    <= n_a;
        r_b    <= n_b;
        r_best <= n_best;
        r_max  <= n_max;
    end

    always_comb begin
        n_state     = r_state;
        n_node      = r_node;
        n_first     = r_first;
        n_cur       = r_cur;
        n_a         = r_a;
        n_b         = r_b;
        n_best      = r_best;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_max       = r_max;

        mem_req       = '0;
        mem_req.waddr = r_node;
        mem_req.raddr = r_node ^ t_addr'(1);

        walk_val = r_first ? r_cur : smax(r_cur, i_mem_rdata);
        fold     = r_pend ? smax(r_best, i_mem_rdata) : r_best;
        q_lo     = (i_left == '0) ? t_pos'(1) : i_left;
        q_hi     = (i_right > i_size) ? i_size : i_right;
        b_dec    = r_b - t_node'(1);

        case (r_state)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = EMPTY_MARK;
                n_node        = r_node + t_addr'(1);
                if (r_node == t_addr'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_WRITE) begin
                        if ((i_left != '0) && (i_left <= i_size)) begin
                            n_node  = t_addr'(CAPACITY) + t_addr'(i_left) - t_addr'(1);
                            n_cur   = i_value;
                            n_first = 1'b1;
                            n_state = ST_WALK;
                        end
                    end else begin
                        n_best = EMPTY_MARK;
                        n_pend = 1'b0;
                        n_a    = t_node'(CAPACITY) + t_node'(q_lo) - t_node'(1);
                        if (q_lo > q_hi) begin
                            n_b = t_node'(CAPACITY) + t_node'(q_lo) - t_node'(1);
                        end else begin
                            n_b = t_node'(CAPACITY) + t_node'(q_hi);
                        end
                        n_state = ST_QA;
                    end
                end
            end
            ST_WALK: begin
                // leaf-to-root refresh, sibling read overlaps the write
                mem_req.we    = 1'b1;
                mem_req.wdata = walk_val;
                mem_req.re    = (r_node != t_addr'(1));
                n_cur         = walk_val;
                n_first       = 1'b0;
                n_node        = r_node >> 1;
                if (r_node == t_addr'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QA: begin
                n_best = fold;
                if (r_a >= r_b) begin
                    n_out_valid = 1'b1;
                    n_max       = fold;
                    n_pend      = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    if (r_a[0]) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_a[ADDR_W-1:0];
                        n_a           = r_a + t_node'(1);
                        n_pend        = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                    n_state = ST_QB;
                end
            end
            ST_QB: begin
                n_best = fold;
                if (r_b[0]) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = b_dec[ADDR_W-1:0];
                    n_b           = b_dec >> 1;
                    n_pend        = 1'b1;
                end else begin
                    n_b    = r_b >> 1;
                    n_pend = 1'b0;
                end
                n_a     = r_a >> 1;
                n_state = ST_QA;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_mem_req = mem_req;
    assign o_busy    = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_maximum = r_max;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_operation == OP_QUERY) |=> o_busy)
        else $error("query transaction did not raise busy");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) == ST_QA && r_state == ST_IDLE))
        else $error("result strobe outside query end");

    a_walk_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_node != '0))
        else $error("update walk reached node zero");

    a_query_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QA || r_state == ST_QB) |-> (r_a <= r_b))
        else $error("query bounds crossed");

    a_no_write_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QA || r_state == ST_QB) |-> !o_mem_req.we)
        else $error("memory write during query");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/range_max_tree_unit.sv
`default_nettype none

// Range-maximum store over positions 1..used_size with point writes. A
// transaction is taken when i_start is high and o_busy is low. After reset
// the node memory is swept to the empty marker, one node a cycle, so o_busy
// stays high until all 2*CAPACITY (2048) nodes are cleared. A write holds
// o_busy while it walks the tree from leaf to root, one tree level per
// cycle, the parent write overlapping the next sibling read; a write outside
// the used positions is dropped at once. During a query the single read
// port of the node memory serves at most one boundary node per cycle, two
// per level. A query answer appears on o_maximum with o_valid high for
// exactly one cycle, at the cycle o_busy falls; the receiver cannot hold
// it off, so it must capture it then. i_cfg_we writes used_size and should
// only be used while the unit is idle.
module range_max_tree_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_operation,
    input  wire rmt_pkg::t_pos         i_left,
    input  wire rmt_pkg::t_pos         i_right,
    input  wire rmt_pkg::t_word        i_value,
    input  wire logic                  i_cfg_we,
    input  wire rmt_pkg::t_pos         i_cfg_wdata,
    output logic                       o_valid,
    output rmt_pkg::t_word             o_maximum
);

    import rmt_pkg::*;

    t_pos     r_used_size;
    t_pos     eff_size;
    t_mem_req mem_req;
    t_word    mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_size <= USED_SIZE_RST;
        end else if (i_cfg_we) begin
            r_used_size <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_used_size == '0) begin
            eff_size = t_pos'(1);
        end else if (32'(r_used_size) > CAPACITY) begin
            eff_size = t_pos'(CAPACITY);
        end else begin
            eff_size = r_used_size;
        end
    end

    rmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_operation (i_operation),
        .i_left      (i_left),
        .i_right     (i_right),
        .i_value     (i_value),
        .i_size      (eff_size),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_valid     (o_valid),
        .o_maximum   (o_maximum)
    );

    rmt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
